>>> design/cpms_pkg.sv
package cpms_pkg;

  localparam int KEY_W    = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DELETE  = 2'd1,
    ACT_COLLECT = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_NO_MEM    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SRC_FIRST  = 2'd0,
    SRC_SECOND = 2'd1,
    SRC_FREE   = 2'd2
  } mark_src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_DATA,
    S_APP_DATA,
    S_DEL_DATA,
    S_MARK_START,
    S_MARK_DATA,
    S_SWEEP_START,
    S_SWEEP_DATA,
    S_FIN
  } state_e;

endpackage

>>> design/cpms_if.sv
interface cpms_in_if;
  logic                                valid;
  logic                                ready;
  logic [cpms_pkg::ACTION_W-1:0]       action;
  logic                                list_select;
  logic signed [cpms_pkg::KEY_W-1:0]   key;

  modport source (output valid, action, list_select, key, input ready);
  modport sink   (input valid, action, list_select, key, output ready);
endinterface

interface cpms_out_if #(
  parameter int CELL_W = 5
);
  logic                          valid;
  logic                          ready;
  logic [cpms_pkg::STATUS_W-1:0] status;
  logic [CELL_W-1:0]             cell_res;
  logic [CELL_W-1:0]             free_head;

  modport source (output valid, status, cell_res, free_head, input ready);
  modport sink   (input valid, status, cell_res, free_head, output ready);
endinterface

>>> design/cpms_cell_mem.sv
module cpms_cell_mem #(
  parameter int CELL_COUNT = 16,
  parameter int CELL_W     = $clog2(CELL_COUNT + 1),
  parameter int WORD_W     = 1 + cpms_pkg::KEY_W + CELL_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [CELL_W-1:0] rd_cell_i,
  output logic [WORD_W-1:0] rd_word_o,
  input  logic              wr_en_i,
  input  logic [CELL_W-1:0] wr_cell_i,
  input  logic [WORD_W-1:0] wr_word_i
);
  import cpms_pkg::*;

  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam logic [CELL_W-1:0] ONE  = CELL_W'(1);
  localparam logic [CELL_W-1:0] LAST = CELL_W'(CELL_COUNT);

  logic [WORD_W-1:0]     mem [CELL_COUNT];
  logic [CELL_COUNT-1:0] valid_q;
  logic [WORD_W-1:0]     rdata_q;
  logic [CELL_W-1:0]     rd_sub;
  logic [CELL_W-1:0]     wr_sub;
  logic [AW-1:0]         rd_idx;
  logic [AW-1:0]         wr_idx;
  logic [CELL_W-1:0]     reset_link;

  assign rd_sub = rd_cell_i - ONE;
  assign wr_sub = wr_cell_i - ONE;
  assign rd_idx = rd_sub[AW-1:0];
  assign wr_idx = wr_sub[AW-1:0];

  // cell i links to i+1 after reset, the last cell to none
  assign reset_link = (rd_cell_i < LAST) ? (rd_cell_i + ONE) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx] <= wr_word_i;
    end
  end

  // same-cycle write to the read cell is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_cell_i == rd_cell_i)) begin
        rdata_q <= wr_word_i;
      end else if (valid_q[rd_idx]) begin
        rdata_q <= mem[rd_idx];
      end else begin
        rdata_q <= {1'b0, {KEY_W{1'b0}}, reset_link};
      end
    end
  end

  assign rd_word_o = rdata_q;

endmodule

>>> design/cell_pool_mark_sweep_heap_top.sv
// Cell pool allocator with two keyed lists, a free list and mark-and-sweep
// collection. Each cell (mark, key, link) lives in one single-port-read,
// single-port-write memory with a registered read; valid bits give every cell
// its reset contents at once, so there is no clearing pass after reset. One
// transaction is worked on at a time, one memory read per visited cell:
// insert walks the chosen list to its tail, delete walks it up to the key,
// collect marks every cell reachable from the three heads and then sweeps all
// cells, and an insert on an empty free list adds one collection. The next
// transaction is taken while a result still waits in the output register.
module cell_pool_mark_sweep_heap_top #(
  parameter int CELL_COUNT = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cpms_in_if.sink      in_i,
  cpms_out_if.source   out_o
);
  import cpms_pkg::*;

  localparam int CW     = $clog2(CELL_COUNT + 1);
  localparam int WORD_W = 1 + KEY_W + CW;
  localparam logic [CW-1:0] N_CW = CW'(CELL_COUNT);
  localparam logic [CW-1:0] ONE  = CW'(1);

  function automatic logic [CW-1:0] vc(input logic [CW-1:0] c);
    return ((c != '0) && (c <= N_CW)) ? c : '0;
  endfunction

  function automatic mark_src_e next_src(input mark_src_e s);
    mark_src_e r;
    unique case (s)
      SRC_FIRST:  r = SRC_SECOND;
      SRC_SECOND: r = SRC_FREE;
      default:    r = SRC_FREE;
    endcase
    return r;
  endfunction

  state_e      state_q, state_d;
  action_e     action_q;
  logic        list_q;
  logic [KEY_W-1:0] key_q;
  logic        collected_q;
  mark_src_e   mark_src_q;
  status_e     status_q;
  logic [CW-1:0] cell_q;
  logic [CW-1:0] cur_q;
  logic [CW-1:0] n_q;
  logic [CW-1:0] prev_q;
  logic [KEY_W-1:0] prev_key_q;
  logic        prev_mark_q;
  logic [CW-1:0] first_q;
  logic [CW-1:0] second_q;
  logic [CW-1:0] free_q;
  logic        out_valid_q;
  status_e     out_status_q;
  logic [CW-1:0] out_cell_q;
  logic [CW-1:0] out_free_q;

  logic              mem_rd_en;
  logic [CW-1:0]     mem_rd_cell;
  logic [WORD_W-1:0] mem_rd_word;
  logic              mem_wr_en;
  logic [CW-1:0]     mem_wr_cell;
  logic [WORD_W-1:0] mem_wr_word;

  logic          rd_mark;
  logic [KEY_W-1:0] rd_key;
  logic [CW-1:0] rd_link;
  logic [CW-1:0] rd_link_v;
  logic [CW-1:0] sel_head_v;
  logic [CW-1:0] in_head_v;
  logic [CW-1:0] free_v;
  logic [CW-1:0] mark_head_v;
  logic          in_fire;
  logic          out_take;
  logic          key_hit;
  logic          n_lt;
  logic          mark_more;
  action_e       in_action;

  assign rd_mark   = mem_rd_word[WORD_W-1];
  assign rd_key    = mem_rd_word[CW +: KEY_W];
  assign rd_link   = mem_rd_word[CW-1:0];
  assign rd_link_v = vc(rd_link);

  assign sel_head_v = vc(list_q ? second_q : first_q);
  assign in_head_v  = vc(in_i.list_select ? second_q : first_q);
  assign free_v     = vc(free_q);
  assign in_action  = action_e'(in_i.action);

  always_comb begin
    unique case (mark_src_q)
      SRC_FIRST:  mark_head_v = vc(first_q);
      SRC_SECOND: mark_head_v = vc(second_q);
      default:    mark_head_v = free_v;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_take   = !out_valid_q || out_o.ready;
  assign key_hit    = (rd_key == key_q);
  assign n_lt       = (n_q < N_CW);
  assign mark_more  = (rd_link_v != '0) && (n_q < (N_CW - ONE));

  cpms_cell_mem #(
    .CELL_COUNT (CELL_COUNT),
    .CELL_W     (CW),
    .WORD_W     (WORD_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_cell_i (mem_rd_cell),
    .rd_word_o (mem_rd_word),
    .wr_en_i   (mem_wr_en),
    .wr_cell_i (mem_wr_cell),
    .wr_word_i (mem_wr_word)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_action)
            ACT_INSERT:  state_d = S_INS_CHK;
            ACT_DELETE:  state_d = (in_head_v != '0) ? S_DEL_DATA : S_FIN;
            ACT_COLLECT: state_d = S_MARK_START;
            default:     state_d = S_FIN;
          endcase
        end
      end
      S_INS_CHK: begin
        priority if (free_v != '0) state_d = S_INS_DATA;
        else if (!collected_q)     state_d = S_MARK_START;
        else                       state_d = S_FIN;
      end
      S_INS_DATA: state_d = (sel_head_v == '0) ? S_FIN : S_APP_DATA;
      S_APP_DATA: begin
        if (!((rd_link_v != '0) && n_lt)) state_d = S_FIN;
      end
      S_DEL_DATA: begin
        if (key_hit || !(n_lt && (rd_link_v != '0))) state_d = S_FIN;
      end
      S_MARK_START: begin
        if (mark_head_v != '0)           state_d = S_MARK_DATA;
        else if (mark_src_q == SRC_FREE) state_d = S_SWEEP_START;
      end
      S_MARK_DATA: begin
        priority if (mark_more)          state_d = S_MARK_DATA;
        else if (mark_src_q == SRC_FREE) state_d = S_SWEEP_START;
        else                             state_d = S_MARK_START;
      end
      S_SWEEP_START: state_d = S_SWEEP_DATA;
      S_SWEEP_DATA: begin
        if (cur_q == N_CW) state_d = (action_q == ACT_INSERT) ? S_INS_CHK : S_FIN;
      end
      S_FIN: begin
        if (out_take) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_cell = '0;
    mem_wr_en   = 1'b0;
    mem_wr_cell = '0;
    mem_wr_word = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (in_action == ACT_DELETE) && (in_head_v != '0)) begin
          mem_rd_en   = 1'b1;
          mem_rd_cell = in_head_v;
        end
      end
      S_INS_CHK: begin
        if (free_v != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_cell = free_v;
        end
      end
      S_INS_DATA: begin
        mem_wr_en   = 1'b1;
        mem_wr_cell = cur_q;
        mem_wr_word = {1'b0, key_q, {CW{1'b0}}};
        if (sel_head_v != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_cell = sel_head_v;
        end
      end
      S_APP_DATA: begin
        if ((rd_link_v != '0) && n_lt) begin
          mem_rd_en   = 1'b1;
          mem_rd_cell = rd_link_v;
        end else if (cur_q != cell_q) begin
          mem_wr_en   = 1'b1;
          mem_wr_cell = cur_q;
          mem_wr_word = {rd_mark, rd_key, cell_q};
        end
      end
      S_DEL_DATA: begin
        if (key_hit) begin
          if (prev_q != '0) begin
            mem_wr_en   = 1'b1;
            mem_wr_cell = prev_q;
            mem_wr_word = {prev_mark_q, prev_key_q, rd_link_v};
          end
        end else if (n_lt && (rd_link_v != '0)) begin
          mem_rd_en   = 1'b1;
          mem_rd_cell = rd_link_v;
        end
      end
      S_MARK_START: begin
        if (mark_head_v != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_cell = mark_head_v;
        end
      end
      S_MARK_DATA: begin
        mem_wr_en   = 1'b1;
        mem_wr_cell = cur_q;
        mem_wr_word = {1'b1, rd_key, rd_link};
        if (mark_more) begin
          mem_rd_en   = 1'b1;
          mem_rd_cell = rd_link_v;
        end
      end
      S_SWEEP_START: begin
        mem_rd_en   = 1'b1;
        mem_rd_cell = ONE;
      end
      S_SWEEP_DATA: begin
        mem_wr_en   = 1'b1;
        mem_wr_cell = cur_q;
        mem_wr_word = rd_mark ? {1'b0, rd_key, rd_link} : {1'b0, {KEY_W{1'b0}}, free_q};
        if (cur_q != N_CW) begin
          mem_rd_en   = 1'b1;
          mem_rd_cell = cur_q + ONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      action_q     <= ACT_NONE;
      list_q       <= 1'b0;
      key_q        <= '0;
      collected_q  <= 1'b0;
      mark_src_q   <= SRC_FIRST;
      status_q     <= STAT_DONE;
      cell_q       <= '0;
      cur_q        <= '0;
      n_q          <= '0;
      prev_q       <= '0;
      prev_key_q   <= '0;
      prev_mark_q  <= 1'b0;
      first_q      <= '0;
      second_q     <= '0;
      free_q       <= ONE;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_DONE;
      out_cell_q   <= '0;
      out_free_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_o.ready && (state_q != S_FIN)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            action_q    <= in_action;
            list_q      <= in_i.list_select;
            key_q       <= in_i.key;
            collected_q <= 1'b0;
            mark_src_q  <= SRC_FIRST;
            status_q    <= STAT_DONE;
            cell_q      <= '0;
            n_q         <= '0;
            prev_q      <= '0;
            cur_q       <= in_head_v;
            if ((in_action == ACT_DELETE) && (in_head_v == '0)) status_q <= STAT_NOT_FOUND;
          end
        end
        S_INS_CHK: begin
          priority if (free_v != '0) begin
            cur_q  <= free_v;
            cell_q <= free_v;
          end else if (!collected_q) begin
            collected_q <= 1'b1;
            mark_src_q  <= SRC_FIRST;
          end else begin
            status_q <= STAT_NO_MEM;
            cell_q   <= '0;
          end
        end
        S_INS_DATA: begin
          free_q <= rd_link_v;
          if (sel_head_v == '0) begin
            if (list_q) second_q <= cur_q;
            else        first_q  <= cur_q;
          end else begin
            cur_q <= sel_head_v;
            n_q   <= '0;
          end
        end
        S_APP_DATA: begin
          if ((rd_link_v != '0) && n_lt) begin
            cur_q <= rd_link_v;
            n_q   <= n_q + ONE;
          end
        end
        S_DEL_DATA: begin
          priority if (key_hit) begin
            cell_q <= cur_q;
            if (prev_q == '0) begin
              if (list_q) second_q <= rd_link_v;
              else        first_q  <= rd_link_v;
            end
          end else if (n_lt && (rd_link_v != '0)) begin
            prev_q      <= cur_q;
            prev_key_q  <= rd_key;
            prev_mark_q <= rd_mark;
            cur_q       <= rd_link_v;
            n_q         <= n_q + ONE;
          end else begin
            status_q <= STAT_NOT_FOUND;
          end
        end
        S_MARK_START: begin
          if (mark_head_v != '0) begin
            cur_q <= mark_head_v;
            n_q   <= '0;
          end else if (mark_src_q != SRC_FREE) begin
            mark_src_q <= next_src(mark_src_q);
          end
        end
        S_MARK_DATA: begin
          if (mark_more) begin
            cur_q <= rd_link_v;
            n_q   <= n_q + ONE;
          end else if (mark_src_q != SRC_FREE) begin
            mark_src_q <= next_src(mark_src_q);
          end
        end
        S_SWEEP_START: cur_q <= ONE;
        S_SWEEP_DATA: begin
          if (!rd_mark) free_q <= cur_q;
          if (cur_q != N_CW) cur_q <= cur_q + ONE;
        end
        S_FIN: begin
          if (out_take) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_cell_q   <= cell_q;
            out_free_q   <= free_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.cell_res  = out_cell_q;
  assign out_o.free_head = out_free_q;

endmodule

>>> dv/cell_pool_mark_sweep_heap_top_tb.sv
module cell_pool_mark_sweep_heap_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpms_pkg::*;

  localparam int CELLS       = 16;
  localparam int CELL_W      = 5;
  localparam int RAND_OPS    = 1750;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 100;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    status_e status;
    cell_t   cell_no;
    cell_t   free_head;
  } reply_t;

  typedef struct packed {
    action_e          act;
    logic             sel;
    logic [KEY_W-1:0] key;
    logic             typed;
    reply_t           reply;
  } row_t;

  logic clk_i;
  logic rst_ni;

  cpms_in_if                     in_if();
  cpms_out_if #(.CELL_W(CELL_W)) out_if();

  cell_pool_mark_sweep_heap_top #(
    .CELL_COUNT(CELLS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // pool image kept alongside the DUT
  logic [KEY_W-1:0] cell_key  [0:CELLS];
  cell_t            cell_next [0:CELLS];
  bit               cell_mark [0:CELLS];
  cell_t            first_hd;
  cell_t            second_hd;
  cell_t            free_hd;

  reply_t due_replies[$];
  row_t   dir_tab[$];

  logic   op_typed;
  reply_t op_reply;
  logic   stall_rq;
  int     mismatches;
  int     idle_cycles;
  int     burst_left;

  function automatic cell_t in_pool(int c);
    return (c >= 1 && c <= CELLS) ? cell_t'(c) : '0;
  endfunction

  function automatic cell_t follow(cell_t c);
    return in_pool(cell_next[in_pool(c)]);
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i <= CELLS; i++) begin
      cell_key[i]  = '0;
      cell_mark[i] = 1'b0;
      cell_next[i] = (i >= 1 && i < CELLS) ? cell_t'(i + 1) : '0;
    end
    first_hd  = '0;
    second_hd = '0;
    free_hd   = cell_t'(1);
  endfunction

  function automatic void mark_chain(cell_t h);
    cell_t c;
    int    n;
    c = in_pool(h);
    n = 0;
    while (c != 0 && n < CELLS) begin
      cell_mark[c] = 1'b1;
      c = follow(c);
      n++;
    end
  endfunction

  function automatic void mark_and_sweep();
    mark_chain(first_hd);
    mark_chain(second_hd);
    mark_chain(free_hd);
    for (int i = 1; i <= CELLS; i++) begin
      if (!cell_mark[i]) begin
        cell_key[i]  = '0;
        cell_next[i] = free_hd;
        free_hd      = cell_t'(i);
      end
      cell_mark[i] = 1'b0;
    end
  endfunction

  function automatic reply_t pool_apply(action_e act, logic sel, logic [KEY_W-1:0] key);
    reply_t r;
    cell_t  hd;
    cell_t  c;
    cell_t  prv;
    cell_t  t;
    int     n;
    r.status  = STAT_DONE;
    r.cell_no = '0;
    hd = sel ? second_hd : first_hd;
    case (act)
      ACT_INSERT: begin
        if (in_pool(free_hd) == 0) mark_and_sweep();
        c = in_pool(free_hd);
        if (c == 0) begin
          r.status = STAT_NO_MEM;
        end else begin
          free_hd      = follow(c);
          cell_key[c]  = key;
          cell_next[c] = '0;
          if (in_pool(hd) == 0) begin
            hd = c;
          end else begin
            t = in_pool(hd);
            n = 0;
            while (follow(t) != 0 && n < CELLS) begin
              t = follow(t);
              n++;
            end
            if (t != c) cell_next[t] = c;
          end
          r.cell_no = c;
        end
      end
      ACT_DELETE: begin
        prv = '0;
        c   = in_pool(hd);
        n   = 0;
        while (c != 0 && cell_key[c] != key && n < CELLS) begin
          prv = c;
          c   = follow(c);
          n++;
        end
        if (c == 0 || cell_key[c] != key) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          if (prv != 0) cell_next[prv] = follow(c);
          else hd = follow(c);
          r.cell_no = c;
        end
      end
      ACT_COLLECT: mark_and_sweep();
      default: ;
    endcase
    if (sel) second_hd = hd;
    else first_hd = hd;
    r.free_head = free_hd;
    return r;
  endfunction

  function automatic row_t mk_row(action_e a, logic s, logic [KEY_W-1:0] k, logic typed,
                                  status_e st, int c, int f);
    row_t r;
    r.act             = a;
    r.sel             = s;
    r.key             = k;
    r.typed           = typed;
    r.reply.status    = st;
    r.reply.cell_no   = cell_t'(c);
    r.reply.free_head = cell_t'(f);
    return r;
  endfunction

  // small key set so deletes usually hit
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h55AA_55AA;
      5, 6: return $urandom;
      default: return 32'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic offer(row_t r);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.action      <= r.act;
    in_if.list_select <= r.sel;
    in_if.key         <= r.key;
    op_typed          <= r.typed;
    op_reply          <= r.reply;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int     n_ops;
    int     seg_left;
    int     ins_pct;
    int     roll;
    bit     hold_done;
    row_t   r;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.action      = ACT_NONE;
    in_if.list_select = 1'b0;
    in_if.key         = '0;
    op_typed          = 1'b0;
    op_reply          = '0;
    stall_rq          = 1'b0;
    mismatches        = 0;
    idle_cycles       = 0;
    burst_left        = 0;
    n_ops             = 0;
    seg_left          = 0;
    ins_pct           = 50;
    hold_done         = 1'b0;
    pool_reset();

    dir_tab.push_back(mk_row(ACT_NONE,    1'b1, 32'hFFFF_FFFF, 1'b1, STAT_DONE,      0, 1));
    dir_tab.push_back(mk_row(ACT_DELETE,  1'b0, 32'h0000_0005, 1'b1, STAT_NOT_FOUND, 0, 1));
    dir_tab.push_back(mk_row(ACT_INSERT,  1'b0, 32'h7FFF_FFFF, 1'b1, STAT_DONE,      1, 2));
    dir_tab.push_back(mk_row(ACT_INSERT,  1'b1, 32'h8000_0000, 1'b1, STAT_DONE,      2, 3));
    dir_tab.push_back(mk_row(ACT_INSERT,  1'b0, 32'hFFFF_FFFF, 1'b1, STAT_DONE,      3, 4));
    dir_tab.push_back(mk_row(ACT_INSERT,  1'b0, 32'h0000_0000, 1'b1, STAT_DONE,      4, 5));
    dir_tab.push_back(mk_row(ACT_DELETE,  1'b1, 32'h7FFF_FFFF, 1'b1, STAT_NOT_FOUND, 0, 5));
    dir_tab.push_back(mk_row(ACT_DELETE,  1'b0, 32'hFFFF_FFFF, 1'b1, STAT_DONE,      3, 5));
    dir_tab.push_back(mk_row(ACT_COLLECT, 1'b1, 32'h0000_0000, 1'b1, STAT_DONE,      0, 3));
    dir_tab.push_back(mk_row(ACT_INSERT,  1'b0, 32'hFFFF_FFFF, 1'b1, STAT_DONE,      3, 5));
    for (int i = 0; i < 12; i++)
      dir_tab.push_back(mk_row(ACT_INSERT, i[0], 32'h100 + i, 1'b0, STAT_DONE, 0, 0));
    // pool full, then a delete leaves garbage that the next insert reclaims
    dir_tab.push_back(mk_row(ACT_INSERT,  1'b0, 32'h1234_5678, 1'b1, STAT_NO_MEM,    0, 0));
    dir_tab.push_back(mk_row(ACT_DELETE,  1'b1, 32'h8000_0000, 1'b1, STAT_DONE,      2, 0));
    dir_tab.push_back(mk_row(ACT_INSERT,  1'b1, 32'h0000_0001, 1'b1, STAT_DONE,      2, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) offer(dir_tab[i]);

    while (n_ops < RAND_OPS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 150);
        ins_pct  = $urandom_range(30, 75);
      end
      seg_left--;
      r    = mk_row(ACT_NONE, 1'($urandom_range(0, 1)), pick_key(), 1'b0, STAT_DONE, 0, 0);
      roll = $urandom_range(0, 99);
      if (roll < 3) r.act = ACT_NONE;
      else if (roll < 10) r.act = ACT_COLLECT;
      else if ($urandom_range(0, 99) < ins_pct) r.act = ACT_INSERT;
      else r.act = ACT_DELETE;
      if (r.act != ACT_NONE) n_ops++;
      if (!hold_done && n_ops >= HOLD_AT) begin
        stall_rq  <= 1'b1;
        hold_done = 1'b1;
      end
      offer(r);
    end
    in_if.valid <= 1'b0;

    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && due_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int mode;
    int left;
    int cyc;
    mode         = 0;
    left         = 0;
    cyc          = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (stall_rq) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        stall_rq <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 128);
        end
        left--;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= (cyc % 4 == 0);
          default: out_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t predicted;
    reply_t want;
    reply_t seen;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predicted = pool_apply(action_e'(in_if.action), in_if.list_select, in_if.key);
        due_replies.push_back(op_typed ? op_reply : predicted);
      end
      if (out_if.valid && out_if.ready) begin
        seen.status    = status_e'(out_if.status);
        seen.cell_no   = out_if.cell_res;
        seen.free_head = out_if.free_head;
        if (due_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: status %0d cell %0d free %0d",
                     seen.status, seen.cell_no, seen.free_head);
        end else begin
          want = due_replies.pop_front();
          if (want.status !== seen.status || want.cell_no !== seen.cell_no ||
              want.free_head !== seen.free_head) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp status %0d cell %0d free %0d, ",
                        "got status %0d cell %0d free %0d"},
                       want.status, want.cell_no, want.free_head,
                       seen.status, seen.cell_no, seen.free_head);
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
design/cpms_pkg.sv
design/cpms_if.sv
design/cpms_cell_mem.sv
design/cell_pool_mark_sweep_heap_top.sv
dv/cell_pool_mark_sweep_heap_top_tb.sv
